/* rtl/ams_pkg.sv */
// ----------------------------------------------------------------------------
// ams_pkg
// Shared types and constants for the decimal accumulator machine.
// ----------------------------------------------------------------------------
`default_nettype none

package ams_pkg;

    // field widths
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 7;
    localparam int OP_W        = 26;
    localparam int OPD_W       = 8;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 176;

    // base of the decimal instruction split
    localparam logic [DATA_W-1:0] DEC_BASE = 32'd100;

    // reciprocal of the base, exact for any 32-bit magnitude
    localparam logic [DATA_W-1:0] DEC_RECIP = 32'h51EB_851F;
    localparam int                DEC_SHIFT = 37;

    // item commands
    localparam logic [CMD_W-1:0] CMD_MEM_WR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXEC    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MEM_RD  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_OP   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NEG_OPD  = 2'd3;

    // opcodes
    localparam logic [OP_W-1:0] OP_READ   = 26'd10;
    localparam logic [OP_W-1:0] OP_WRITE  = 26'd11;
    localparam logic [OP_W-1:0] OP_LOAD   = 26'd20;
    localparam logic [OP_W-1:0] OP_STORE  = 26'd21;
    localparam logic [OP_W-1:0] OP_ADD    = 26'd30;
    localparam logic [OP_W-1:0] OP_SUB    = 26'd31;
    localparam logic [OP_W-1:0] OP_DIV    = 26'd32;
    localparam logic [OP_W-1:0] OP_MUL    = 26'd33;
    localparam logic [OP_W-1:0] OP_BR     = 26'd40;
    localparam logic [OP_W-1:0] OP_BRNEG  = 26'd41;
    localparam logic [OP_W-1:0] OP_BRZERO = 26'd42;
    localparam logic [OP_W-1:0] OP_HALT   = 26'd43;

    // controller to datapath commands
    typedef struct packed {
        logic                ld_in;
        logic                mem_wr_cmd;
        logic                rd_pc;
        logic                rd_addr;
        logic                rd_opd;
        logic                ld_word;
        logic                dec_go;
        logic                div_acc;
        logic                ld_dec;
        logic                ld_mval;
        logic                ld_rdata;
        logic                mul_go;
        logic                ld_res;
        logic                commit;
        logic                restart;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                ld_out;
    } ams_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             halted;
        logic             div_busy;
        logic             div_done;
        logic             dec_done;
        logic             opd_neg;
        logic             op_bad;
        logic             op_div;
        logic             op_mul;
        logic             mval_zero;
    } ams_sts_t;

    // true for an opcode the machine executes
    function automatic logic op_known(input logic [OP_W-1:0] op);
        return (op == OP_READ)  || (op == OP_WRITE) || (op == OP_LOAD)  ||
               (op == OP_STORE) || (op == OP_ADD)   || (op == OP_SUB)   ||
               (op == OP_DIV)   || (op == OP_MUL)   || (op == OP_BR)    ||
               (op == OP_BRNEG) || (op == OP_BRZERO) || (op == OP_HALT);
    endfunction

endpackage

`default_nettype wire

/* rtl/ams_div.sv */
// ----------------------------------------------------------------------------
// ams_div
// Signed 32-bit divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ams_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [ams_pkg::DATA_W-1:0] dividend,
    input  wire logic [ams_pkg::DATA_W-1:0] divisor,
    output logic                           busy,
    output logic                           done,
    output logic [ams_pkg::DATA_W-1:0]     quotient
);
    import ams_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] den_reg;
    logic              negq_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    // trial subtract of one step
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // magnitudes and shift
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg  <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            quo_reg  <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg  <= '0;
            negq_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                rem_reg <= diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = negq_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

`default_nettype wire

/* rtl/ams_datapath.sv */
// ----------------------------------------------------------------------------
// ams_datapath
// Word memory, machine registers, decimal split, multiplier, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ams_datapath #(
    parameter int MEM_WORDS = 100
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire ams_pkg::ams_cmd_t               cmd,
    output ams_pkg::ams_sts_t                    sts,
    input  wire logic [ams_pkg::IN_TDATA_W-1:0]  in_tdata,
    input  wire logic [ams_pkg::CMD_W-1:0]       in_tuser,
    output logic [ams_pkg::OUT_TDATA_W-1:0]      out_tdata,
    output logic                                 out_tuser
);
    import ams_pkg::*;

    localparam int IDX_W = $clog2(MEM_WORDS);

    // latched item
    logic [CMD_W-1:0]  cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] inval_reg;

    // machine state
    logic [DATA_W-1:0] acc_reg;
    logic [ADDR_W-1:0] pc_reg;
    logic [DATA_W-1:0] ir_reg;
    logic [OP_W-1:0]   op_reg;
    logic [OPD_W-1:0]  opd_reg;
    logic              halt_reg;

    // working registers of one instruction
    logic [DATA_W-1:0] word_reg;
    logic [OP_W-1:0]   wop_reg;
    logic [OPD_W-1:0]  wopd_reg;
    logic [DATA_W-1:0] mval_reg;
    logic [DATA_W-1:0] res_reg;

    // per-item result parts
    logic [STATUS_W-1:0] status_reg;
    logic [DATA_W-1:0]   pval_reg;
    logic                pvalid_reg;
    logic [DATA_W-1:0]   rdata_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_user_reg;

    // memory and its valid bits
    logic [DATA_W-1:0]    mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] vld_reg;
    logic [DATA_W-1:0]    rd_raw_reg;
    logic                 rd_vld_reg;
    logic [DATA_W-1:0]    rd_data;

    logic              addr_ok;
    logic [ADDR_W-1:0] rd_idx;
    logic              rd_ok;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_idx;
    logic [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0] pc_inc;
    logic [ADDR_W-1:0] opd_addr;
    logic [DATA_W-1:0] mul_lo;

    // decimal split pipeline
    logic [DATA_W-1:0]   dec_mag_reg;
    logic                dec_neg_reg;
    logic [2*DATA_W-1:0] dec_prod_reg;
    logic                dec_v1_reg;
    logic                dec_v2_reg;
    logic                dec_done_reg;
    logic [OP_W-1:0]     dec_q_reg;
    logic [OPD_W-1:0]    dec_r_reg;
    logic [DATA_W-1:0]   dec_quo;
    logic [DATA_W-1:0]   dec_rem;

    logic              div_start;
    logic [DATA_W-1:0] div_a;
    logic [DATA_W-1:0] div_b;
    logic              div_busy;
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    assign addr_ok  = {1'b0, addr_reg} < (ADDR_W+1)'(MEM_WORDS);
    assign opd_addr = wopd_reg[ADDR_W-1:0];
    assign pc_inc   = (({1'b0, pc_reg} + 1'b1) >= (ADDR_W+1)'(MEM_WORDS)) ?
                      '0 : pc_reg + 1'b1;
    assign mul_lo   = acc_reg * mval_reg;

    // read address selection
    always_comb begin
        rd_en  = cmd.rd_pc | cmd.rd_addr | cmd.rd_opd;
        rd_ok  = 1'b1;
        rd_idx = pc_reg;
        if (cmd.rd_addr) begin
            rd_idx = addr_reg;
            rd_ok  = addr_ok;
        end else if (cmd.rd_opd) begin
            rd_idx = opd_addr;
        end
    end

    // write port selection
    always_comb begin
        wr_en   = (cmd.mem_wr_cmd && addr_ok) ||
                  (cmd.commit && ((wop_reg == OP_READ) || (wop_reg == OP_STORE)));
        wr_idx  = cmd.mem_wr_cmd ? addr_reg : opd_addr;
        wr_data = cmd.mem_wr_cmd ? data_reg :
                  ((wop_reg == OP_READ) ? inval_reg : acc_reg);
    end

    // memory array
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx[IDX_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            rd_raw_reg <= mem[rd_idx[IDX_W-1:0]];
        end
    end

    // valid bits, never-written words read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_idx[IDX_W-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= rd_ok ? vld_reg[rd_idx[IDX_W-1:0]] : 1'b0;
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

    // decimal split: magnitude, reciprocal multiply, signed quotient and remainder
    assign dec_quo = DATA_W'(dec_prod_reg[2*DATA_W-1:DEC_SHIFT]);
    assign dec_rem = dec_mag_reg - dec_quo * DEC_BASE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_v1_reg   <= 1'b0;
            dec_v2_reg   <= 1'b0;
            dec_done_reg <= 1'b0;
        end else begin
            dec_v1_reg   <= cmd.dec_go;
            dec_v2_reg   <= dec_v1_reg;
            dec_done_reg <= dec_v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dec_go) begin
            dec_mag_reg <= word_reg[DATA_W-1] ? (~word_reg + 1'b1) : word_reg;
            dec_neg_reg <= word_reg[DATA_W-1];
        end
        if (dec_v1_reg) begin
            dec_prod_reg <= dec_mag_reg * DEC_RECIP;
        end
        if (dec_v2_reg) begin
            dec_q_reg <= dec_neg_reg ? (~dec_quo[OP_W-1:0] + 1'b1) : dec_quo[OP_W-1:0];
            dec_r_reg <= dec_neg_reg ? (~dec_rem[OPD_W-1:0] + 1'b1) : dec_rem[OPD_W-1:0];
        end
    end

    // divider for the divide instruction
    assign div_start = cmd.div_acc;
    assign div_a     = acc_reg;
    assign div_b     = mval_reg;

    ams_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q)
    );

    // item latch and working registers
    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            cmd_reg   <= in_tuser;
            addr_reg  <= in_tdata[ADDR_W-1:0];
            data_reg  <= in_tdata[ADDR_W +: DATA_W];
            inval_reg <= in_tdata[ADDR_W+DATA_W +: DATA_W];
        end
        if (cmd.ld_word) begin
            word_reg <= rd_data;
        end
        if (cmd.ld_dec) begin
            wop_reg  <= dec_q_reg;
            wopd_reg <= dec_r_reg;
        end
        if (cmd.ld_mval) begin
            mval_reg <= rd_data;
        end
        if (cmd.mul_go) begin
            res_reg <= mul_lo;
        end else if (cmd.ld_res) begin
            res_reg <= div_q;
        end
        if (cmd.ld_out) begin
            out_data_reg <= {4'b0, rdata_reg, status_reg, halt_reg, pval_reg,
                             opd_reg, op_reg, ir_reg, pc_reg, acc_reg};
            out_user_reg <= pvalid_reg;
        end
    end

    // machine registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            pc_reg     <= '0;
            ir_reg     <= '0;
            op_reg     <= '0;
            opd_reg    <= '0;
            halt_reg   <= 1'b0;
            status_reg <= ST_OK;
            pval_reg   <= '0;
            pvalid_reg <= 1'b0;
            rdata_reg  <= '0;
        end else begin
            if (cmd.ld_in) begin
                status_reg <= ST_OK;
                pval_reg   <= '0;
                pvalid_reg <= 1'b0;
                rdata_reg  <= '0;
            end
            if (cmd.set_status) begin
                status_reg <= cmd.status;
            end
            if (cmd.ld_rdata) begin
                rdata_reg <= rd_data;
            end
            if (cmd.restart) begin
                acc_reg  <= '0;
                pc_reg   <= '0;
                halt_reg <= 1'b0;
            end
            if (cmd.commit) begin
                ir_reg  <= word_reg;
                op_reg  <= wop_reg;
                opd_reg <= wopd_reg;
                pc_reg  <= pc_inc;
                case (wop_reg)
                    OP_WRITE: begin
                        pval_reg   <= mval_reg;
                        pvalid_reg <= 1'b1;
                    end
                    OP_LOAD:  acc_reg <= mval_reg;
                    OP_ADD:   acc_reg <= acc_reg + mval_reg;
                    OP_SUB:   acc_reg <= acc_reg - mval_reg;
                    OP_DIV, OP_MUL: acc_reg <= res_reg;
                    OP_BR:    pc_reg <= opd_addr;
                    OP_BRNEG: pc_reg <= acc_reg[DATA_W-1] ? opd_addr : pc_inc;
                    OP_BRZERO: pc_reg <= (acc_reg == '0) ? opd_addr : pc_inc;
                    OP_HALT: begin
                        halt_reg <= 1'b1;
                        pc_reg   <= pc_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    // status to controller
    always_comb begin
        sts.cmd       = cmd_reg;
        sts.halted    = halt_reg;
        sts.div_busy  = div_busy;
        sts.div_done  = div_done;
        sts.dec_done  = dec_done_reg;
        sts.opd_neg   = wopd_reg[OPD_W-1];
        sts.op_bad    = !op_known(wop_reg);
        sts.op_div    = (wop_reg == OP_DIV);
        sts.op_mul    = (wop_reg == OP_MUL);
        sts.mval_zero = (mval_reg == '0);
    end

    assign out_tdata = out_data_reg;
    assign out_tuser = out_user_reg;

endmodule

`default_nettype wire

/* rtl/ams_ctrl.sv */
// ----------------------------------------------------------------------------
// ams_ctrl
// Sequencer for one item: dispatch, fetch, decode, fault checks, execute.
// ----------------------------------------------------------------------------
`default_nettype none

module ams_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire ams_pkg::ams_sts_t sts,
    output ams_pkg::ams_cmd_t      cmd
);
    import ams_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DISP   = 12'b0000_0000_0010,
        S_FWAIT  = 12'b0000_0000_0100,
        S_DECS   = 12'b0000_0000_1000,
        S_DECW   = 12'b0000_0001_0000,
        S_CHK    = 12'b0000_0010_0000,
        S_OPRW   = 12'b0000_0100_0000,
        S_EXS    = 12'b0000_1000_0000,
        S_EXW    = 12'b0001_0000_0000,
        S_COMMIT = 12'b0010_0000_0000,
        S_RWAIT  = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.ld_in  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                unique case (sts.cmd)
                    CMD_MEM_WR: begin
                        cmd.mem_wr_cmd = 1'b1;
                        state_next     = S_DONE;
                    end
                    CMD_EXEC: begin
                        if (sts.halted) begin
                            state_next = S_DONE;
                        end else begin
                            cmd.rd_pc  = 1'b1;
                            state_next = S_FWAIT;
                        end
                    end
                    CMD_MEM_RD: begin
                        cmd.rd_addr = 1'b1;
                        state_next  = S_RWAIT;
                    end
                    default: begin
                        cmd.restart = 1'b1;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_RWAIT: begin
                cmd.ld_rdata = 1'b1;
                state_next   = S_DONE;
            end
            S_FWAIT: begin
                cmd.ld_word = 1'b1;
                state_next  = S_DECS;
            end
            S_DECS: begin
                cmd.dec_go = 1'b1;
                state_next = S_DECW;
            end
            S_DECW: begin
                if (sts.dec_done) begin
                    cmd.ld_dec = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (sts.opd_neg) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NEG_OPD;
                    state_next     = S_DONE;
                end else if (sts.op_bad) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_BAD_OP;
                    state_next     = S_DONE;
                end else begin
                    cmd.rd_opd = 1'b1;
                    state_next = S_OPRW;
                end
            end
            S_OPRW: begin
                cmd.ld_mval = 1'b1;
                state_next  = S_EXS;
            end
            S_EXS: begin
                if (sts.op_div && sts.mval_zero) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_DIV_ZERO;
                    state_next     = S_DONE;
                end else if (sts.op_div) begin
                    cmd.div_acc = 1'b1;
                    state_next  = S_EXW;
                end else begin
                    cmd.mul_go = sts.op_mul;
                    state_next = S_COMMIT;
                end
            end
            S_EXW: begin
                if (sts.div_done) begin
                    cmd.ld_res = 1'b1;
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.ld_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // output beat valid
    always_comb begin
        if (cmd.ld_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_out |-> (!m_valid_reg || m_tready))
        else $error("result register loaded over an untaken beat");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_acc |-> !sts.div_busy)
        else $error("divider started while busy");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_DISP))
        else $error("accepted beat not dispatched");

    a_commit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!sts.opd_neg && !sts.op_bad && !sts.halted))
        else $error("faulting instruction committed");
`endif

endmodule

`default_nettype wire

/* rtl/accumulator_machine_step.sv */
// ----------------------------------------------------------------------------
// accumulator_machine_step
// Decimal accumulator machine with a word memory, one command per beat.
// ----------------------------------------------------------------------------
// Each input beat carries a command: write a memory word, execute one
// instruction, read a memory word back, or restart; each gives exactly one
// result beat. Execute runs a fetch from the word memory, a three-stage
// reciprocal multiply that splits the word into opcode and operand, then
// the operand word read. A divide instruction also runs on a bit-serial
// divider. An execute that faults on its operand or opcode, or divides by
// zero, stops before its commit, and an execute on a halted machine does
// no fetch. A waiting result beat holds the item in its last state. A new
// beat is taken once the previous item has moved into the result register,
// even while that result still waits. Words never written read as zero
// after reset, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module accumulator_machine_step #(
    parameter int MEM_WORDS = 100
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // address[6:0], data[38:7], in_value[70:39], zero pad
    input  wire logic [ams_pkg::IN_TDATA_W-1:0]    s_tdata,
    // command[1:0]
    input  wire logic [ams_pkg::CMD_W-1:0]         s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // acc_out[31:0], counter_out[38:32], instr_out[70:39], opcode_out[96:71],
    // operand_out[104:97], print_value[136:105], halted[137], status[139:138],
    // read_data[171:140], zero pad
    output logic [ams_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // print_valid[0]
    output logic                                   m_tuser
);
    import ams_pkg::*;

    ams_cmd_t cmd;
    ams_sts_t sts;

    // sequencer
    ams_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // memory, registers and arithmetic
    ams_datapath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_tdata  (s_tdata),
        .in_tuser  (s_tuser),
        .out_tdata (m_tdata),
        .out_tuser (m_tuser)
    );

endmodule

`default_nettype wire

/* dv/accumulator_machine_step_test.sv */
// ----------------------------------------------------------------------------
// accumulator_machine_step_test
// Self-checking bench for the decimal accumulator machine.
// ----------------------------------------------------------------------------
// Drives command beats (memory write, execute, memory read, restart) on the
// input stream, keeps its own model of memory, accumulator, counter,
// instruction register and halt flag, and checks every result beat field by
// field. A directed table comes first, then small random programs with
// random content, mixed with noise and out-of-range accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module accumulator_machine_step_test;
    import ams_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_N       = 100;
    localparam int N_RANDOM    = 1330;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 200;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] inval;
    } beat_in_t;

    typedef struct packed {
        logic [DATA_W-1:0]   acc;
        logic [ADDR_W-1:0]   counter;
        logic [DATA_W-1:0]   instr;
        logic [OP_W-1:0]     opcode;
        logic [OPD_W-1:0]    operand;
        logic [DATA_W-1:0]   pval;
        logic                pvalid;
        logic                halted;
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   rdata;
    } beat_out_t;

    // directed row: stimulus, optional typed-in result
    typedef struct {
        beat_in_t  stim;
        bit        fixed;
        beat_out_t want;
    } row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    // machine model
    logic [DATA_W-1:0] mdl_mem [MEM_N];
    logic [DATA_W-1:0] mdl_acc;
    logic [ADDR_W-1:0] mdl_pc;
    logic [DATA_W-1:0] mdl_ir;
    logic              mdl_halt;

    beat_out_t expected_q[$];
    beat_in_t  stim_q[$];
    int        n_fail;
    int        n_mismatch;
    int        n_results;
    int        n_exec_ok;
    int        n_faults;
    int        idle_cycles;
    bit        hold_rx;
    bit        timed_out;

    accumulator_machine_step u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic [ADDR_W-1:0] pc_next(input logic [ADDR_W-1:0] pc);
        return (pc + 1 >= MEM_N) ? '0 : pc + 1'b1;
    endfunction

    // one command against the model, gives the expected result
    function automatic beat_out_t machine_step(input beat_in_t b);
        beat_out_t         r;
        logic signed [31:0] w;
        logic signed [31:0] op;
        logic signed [31:0] opd;
        logic signed [31:0] accs;
        logic signed [31:0] m;
        logic [ADDR_W-1:0]  a;
        logic [ADDR_W-1:0]  pc;
        r = '0;
        case (b.cmd)
            CMD_MEM_WR: begin
                if (b.addr < MEM_N) mdl_mem[b.addr] = b.data;
            end
            CMD_MEM_RD: begin
                if (b.addr < MEM_N) r.rdata = mdl_mem[b.addr];
            end
            CMD_RESTART: begin
                mdl_acc = '0;
                mdl_pc = '0;
                mdl_halt = 1'b0;
            end
            default: begin
                if (!mdl_halt) begin
                    pc = mdl_pc % MEM_N;
                    w = mdl_mem[pc];
                    op = w / 100;
                    opd = w % 100;
                    accs = mdl_acc;
                    if (opd < 0) r.status = ST_NEG_OPD;
                    else if (!op_known(op[OP_W-1:0]) || op > 43 || op < 0)
                        r.status = ST_BAD_OP;
                    else begin
                        a = opd[ADDR_W-1:0];
                        m = mdl_mem[a];
                        if (op[OP_W-1:0] == OP_DIV && m == 0) r.status = ST_DIV_ZERO;
                    end
                    if (r.status == ST_OK) begin
                        mdl_ir = w;
                        case (op[OP_W-1:0])
                            OP_READ:   begin mdl_mem[a] = b.inval; pc = pc_next(pc); end
                            OP_WRITE:  begin
                                r.pval = mdl_mem[a];
                                r.pvalid = 1'b1;
                                pc = pc_next(pc);
                            end
                            OP_LOAD:   begin mdl_acc = mdl_mem[a]; pc = pc_next(pc); end
                            OP_STORE:  begin mdl_mem[a] = mdl_acc; pc = pc_next(pc); end
                            OP_ADD:    begin mdl_acc = mdl_acc + mdl_mem[a]; pc = pc_next(pc); end
                            OP_SUB:    begin mdl_acc = mdl_acc - mdl_mem[a]; pc = pc_next(pc); end
                            OP_DIV:    begin
                                // most negative over -1 wraps to itself
                                if (accs == 32'sh8000_0000 && m == -1) mdl_acc = accs;
                                else mdl_acc = accs / m;
                                pc = pc_next(pc);
                            end
                            OP_MUL:    begin mdl_acc = accs * m; pc = pc_next(pc); end
                            OP_BR:     pc = a;
                            OP_BRNEG:  pc = (accs < 0) ? a : pc_next(pc);
                            OP_BRZERO: pc = (accs == 0) ? a : pc_next(pc);
                            default:   mdl_halt = 1'b1;
                        endcase
                        mdl_pc = pc;
                    end
                end
            end
        endcase
        w = mdl_ir;
        op = w / 100;
        opd = w % 100;
        r.acc = mdl_acc;
        r.counter = mdl_pc;
        r.instr = mdl_ir;
        r.opcode = op[OP_W-1:0];
        r.operand = opd[OPD_W-1:0];
        r.halted = mdl_halt;
        return r;
    endfunction

    function automatic beat_in_t mk(input logic [CMD_W-1:0] c, input int addr,
                                    input logic [31:0] d, input logic [31:0] v);
        beat_in_t b;
        b.cmd = c;
        b.addr = addr[ADDR_W-1:0];
        b.data = d;
        b.inval = v;
        return b;
    endfunction

    function automatic logic [31:0] instr_word(input int op, input int opd);
        return op * 100 + opd;
    endfunction

    // random instruction word, mostly well formed
    function automatic logic [31:0] rand_instr();
        int ops[12] = '{10, 11, 20, 21, 30, 31, 32, 33, 40, 41, 42, 43};
        int k;
        k = $urandom_range(0, 99);
        if (k < 85) return instr_word(ops[$urandom_range(0, 11)], $urandom_range(0, 99));
        if (k < 90) return -$signed({1'b0, $urandom_range(1, 100000)});
        if (k < 95) return instr_word($urandom_range(0, 60), $urandom_range(0, 99));
        return $urandom();
    endfunction

    function automatic logic [31:0] rand_data();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 9);
            default: return $urandom();
        endcase
    endfunction

    // compare a result beat with the oldest expectation
    task automatic check_beat(input beat_out_t got);
        beat_out_t want;
        if (expected_q.size() == 0) begin
            n_fail++;
            if (n_mismatch < 10) $display("unexpected result beat %h", got);
            n_mismatch++;
        end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
                n_fail++;
                if (n_mismatch < 10) begin
                    $display("mismatch at result %0d", n_results);
                    $display("  acc %h/%h pc %0d/%0d ir %h/%h op %h/%h opd %h/%h",
                             want.acc, got.acc, want.counter, got.counter,
                             want.instr, got.instr, want.opcode, got.opcode,
                             want.operand, got.operand);
                    $display("  pv %h/%h pvd %b/%b halt %b/%b st %0d/%0d rd %h/%h",
                             want.pval, got.pval, want.pvalid, got.pvalid,
                             want.halted, got.halted, want.status, got.status,
                             want.rdata, got.rdata);
                end
                n_mismatch++;
            end
        end
        n_results++;
    endtask

    // result side: stall pattern plus a long hold-off on request
    initial begin
        int phase;
        m_tready = 1'b0;
        phase = 0;
        forever begin
            @(posedge aclk);
            if (hold_rx) m_tready <= 1'b0;
            else begin
                phase++;
                m_tready <= ((phase % 11) < 7) ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        beat_out_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(beat_out_t)-1+0:0] ;
            got.acc     = m_tdata[31:0];
            got.counter = m_tdata[38:32];
            got.instr   = m_tdata[70:39];
            got.opcode  = m_tdata[96:71];
            got.operand = m_tdata[104:97];
            got.pval    = m_tdata[136:105];
            got.pvalid  = m_tuser;
            got.halted  = m_tdata[137];
            got.status  = m_tdata[139:138];
            got.rdata   = m_tdata[171:140];
            check_beat(got);
        end
    end

    // watchdog on accepted beats
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_rx)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("accumulator_machine_step verification failed");
            $finish;
        end
    end

    // send one beat, predicting at acceptance
    task automatic send(input beat_in_t b, input bit fixed, input beat_out_t want);
        beat_out_t pred;
        s_tvalid <= 1'b1;
        s_tuser  <= b.cmd;
        s_tdata  <= {1'b0, b.inval, b.data, b.addr};
        do @(posedge aclk); while (!s_tready);
        pred = machine_step(b);
        if (b.cmd == CMD_EXEC && !fixed) begin
            if (pred.status == ST_OK) n_exec_ok++;
            else n_faults++;
        end
        expected_q.push_back(fixed ? want : pred);
    endtask

    task automatic gap();
        int n;
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 20);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        row_t      rows[$];
        row_t      r;
        beat_out_t z;
        beat_in_t  b;
        int        burst;
        int        sent;
        int        k;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_MEM_WR;
        hold_rx = 1'b0;
        n_fail = 0;
        n_mismatch = 0;
        n_results = 0;
        n_exec_ok = 0;
        n_faults = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        foreach (mdl_mem[i]) mdl_mem[i] = '0;
        mdl_acc = '0;
        mdl_pc = '0;
        mdl_ir = '0;
        mdl_halt = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        z = '0;
        r.fixed = 1'b1; r.want = z;
        r.stim = mk(CMD_MEM_RD, 99, 0, 0); rows.push_back(r);
        r.stim = mk(CMD_MEM_RD, 127, 0, 0); rows.push_back(r);
        r.stim = mk(CMD_MEM_WR, 127, 32'hFFFF_FFFF, 0); rows.push_back(r);
        r.stim = mk(CMD_MEM_WR, 0, -32'sd5, 0); rows.push_back(r);
        r.want.status = ST_NEG_OPD;
        r.stim = mk(CMD_EXEC, 0, 0, 32'hFFFF_FFFF); rows.push_back(r);
        r.want = z;
        r.stim = mk(CMD_MEM_WR, 0, 32'd9999, 0); rows.push_back(r);
        r.want.status = ST_BAD_OP;
        r.stim = mk(CMD_EXEC, 0, 0, 0); rows.push_back(r);
        r.fixed = 1'b0;
        // divide by zero, then a full program
        r.stim = mk(CMD_MEM_WR, 0, instr_word(32, 50), 0); rows.push_back(r);
        r.stim = mk(CMD_EXEC, 0, 0, 0); rows.push_back(r);
        r.stim = mk(CMD_MEM_WR, 0, instr_word(10, 50), 0); rows.push_back(r);
        r.stim = mk(CMD_MEM_WR, 1, instr_word(20, 50), 0); rows.push_back(r);
        r.stim = mk(CMD_MEM_WR, 2, instr_word(32, 51), 0); rows.push_back(r);
        r.stim = mk(CMD_MEM_WR, 3, instr_word(33, 51), 0); rows.push_back(r);
        r.stim = mk(CMD_MEM_WR, 4, instr_word(31, 51), 0); rows.push_back(r);
        r.stim = mk(CMD_MEM_WR, 5, instr_word(11, 50), 0); rows.push_back(r);
        r.stim = mk(CMD_MEM_WR, 51, 32'hFFFF_FFFF, 0); rows.push_back(r);
        r.stim = mk(CMD_MEM_WR, 6, instr_word(43, 0), 0); rows.push_back(r);
        r.stim = mk(CMD_EXEC, 0, 0, 32'h8000_0000); rows.push_back(r);
        for (int i = 0; i < 8; i++) begin
            r.stim = mk(CMD_EXEC, 0, 0, 0); rows.push_back(r);
        end
        r.stim = mk(CMD_MEM_RD, 50, 0, 0); rows.push_back(r);
        r.stim = mk(CMD_RESTART, 0, 0, 0); rows.push_back(r);
        foreach (rows[i]) send(rows[i].stim, rows[i].fixed, rows[i].want);
        wait_drain();

        // random part: a random mix of program loads, executes, reads and restarts
        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            k = $urandom_range(0, 99);
            if (k < 40) begin
                b = mk(CMD_MEM_WR, $urandom_range(0, 99), rand_instr(), $urandom());
                if ($urandom_range(0, 2) == 0) b.data = rand_data();
            end else if (k < 80) b = mk(CMD_EXEC, $urandom(), $urandom(), rand_data());
            else if (k < 90) b = mk(CMD_MEM_RD, $urandom_range(0, 127), $urandom(), $urandom());
            else if (k < 95) b = mk(CMD_MEM_WR, $urandom_range(0, 127), rand_data(), $urandom());
            else b = mk(CMD_RESTART, $urandom(), $urandom(), $urandom());
            if (sent == 400) begin
                // long receiver hold-off while offering beats
                hold_rx = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge aclk);
                        hold_rx = 1'b0;
                    end
                join_none
            end
            if (sent == 800) wait_drain();
            send(b, 1'b0, z);
            sent++;
            if (sent % burst == 0) gap();
        end
        wait_drain();
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("ran %0d result beats: %0d clean executes, %0d faulting executes",
                 n_results, n_exec_ok, n_faults);
        if (n_fail == 0 && expected_q.size() == 0)
            $display("accumulator_machine_step verification clean");
        else begin
            $display("%0d mismatches, %0d results missing", n_mismatch, expected_q.size());
            $display("accumulator_machine_step verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/ams_pkg.sv
rtl/ams_div.sv
rtl/ams_datapath.sv
rtl/ams_ctrl.sv
rtl/accumulator_machine_step.sv
dv/accumulator_machine_step_test.sv
